// ===== sv/assert_macros.svh =====
// Assertion macros used by the back end RTL module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/tfll_pkg.sv =====
// Package: constants, types and helpers of the tumor fraction log likelihood block
`default_nettype none
package tfll_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int SUM_WIDTH     = 40;
    localparam int PROB_W        = FRAC_BITS + 1;
    localparam int CNT_W         = 16;
    localparam int GP_W          = 4;
    localparam int CHAR_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int LOG_MANT_BITS = 30;
    localparam int LOG_FRAC_BITS = 28;
    localparam int LN2_W         = 30;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

    localparam logic [PROB_W-1:0] ONE  = PROB_W'(1) << FRAC_BITS;
    localparam logic [PROB_W-1:0] HALF = PROB_W'(1) << (FRAC_BITS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TUMOR_FRACTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENOTYPE_PAIR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_BASE       = 2'd2;

    localparam logic [GP_W-1:0] GP_AA_AA = 4'd0;
    localparam logic [GP_W-1:0] GP_AA_AB = 4'd1;
    localparam logic [GP_W-1:0] GP_AA_BB = 4'd2;
    localparam logic [GP_W-1:0] GP_AB_AA = 4'd3;
    localparam logic [GP_W-1:0] GP_AB_AB = 4'd4;
    localparam logic [GP_W-1:0] GP_AB_BB = 4'd5;
    localparam logic [GP_W-1:0] GP_BB_AA = 4'd6;
    localparam logic [GP_W-1:0] GP_BB_AB = 4'd7;
    localparam logic [GP_W-1:0] GP_BB_BB = 4'd8;

    localparam logic [CHAR_W-1:0] CH_UPPER_R = 8'd82;
    localparam logic [CHAR_W-1:0] CH_LOWER_R = 8'd114;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'd88;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
    localparam logic [CHAR_W-1:0] CASE_GAP   = 8'd32;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [PROB_W-1:0] q;
        logic [PROB_W-1:0] m;
        logic [PROB_W-1:0] v;
        logic              counted;
        logic              last;
    } t_work;

    function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
        lower_ascii = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
    endfunction

    function automatic logic [PROB_W-1:0] clamp_one(input logic [PROB_W-1:0] x);
        clamp_one = (x > ONE) ? ONE : x;
    endfunction

endpackage
`default_nettype wire

// ===== sv/tumor_fraction_log_likelihood.sv =====
// Top level of the tumor fraction log likelihood block
`default_nettype none
// Streams the bases of one pileup column and returns the summed natural log
// likelihood, the counted-base total and a floor flag on the base marked last.
// The input and result sides are queues (push/full, pop/empty). A counted base
// holds the back end from the two-entry queue through the product stages MUL1
// and MUL2, the normalize stage, the bit-serial log (one squaring per fraction
// bit on a reused 31x31 multiplier), the ln2 scaling and the accumulate step.
// An uncounted base goes from idle to accumulate; a zero term skips the log.
// A last base holds in accumulate while the previous word waits unpopped. The
// user must write configuration only while idle; the block does not check it.
module tumor_fraction_log_likelihood (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [tfll_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [tfll_pkg::PROB_W-1:0]           i_cfg_data,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic [tfll_pkg::CHAR_W-1:0]           i_base_char,
    input  wire logic [tfll_pkg::PROB_W-1:0]           i_base_err,
    input  wire logic [tfll_pkg::PROB_W-1:0]           i_map_err,
    input  wire logic                                  i_last,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [tfll_pkg::SUM_WIDTH-1:0]      o_log_likelihood,
    output logic [tfll_pkg::CNT_W-1:0]                 o_used_count,
    output logic                                       o_floor_hit
);

    tfll_pkg::t_work work_in;
    tfll_pkg::t_work work_out;
    logic            q_valid;
    logic            q_take;

    tfll_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_base_char (i_base_char),
        .i_base_err  (i_base_err),
        .i_map_err   (i_map_err),
        .i_last      (i_last),
        .o_work      (work_in)
    );

    tfll_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (work_in),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_take),
        .o_data  (work_out)
    );

    tfll_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_work           (work_out),
        .o_take           (q_take),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_log_likelihood (o_log_likelihood),
        .o_used_count     (o_used_count),
        .o_floor_hit      (o_floor_hit)
    );

endmodule
`default_nettype wire

// ===== sv/tfll_front.sv =====
// Front end: configuration registers and base classification
`default_nettype none
module tfll_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tfll_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tfll_pkg::PROB_W-1:0]    i_cfg_data,
    input  wire logic [tfll_pkg::CHAR_W-1:0]    i_base_char,
    input  wire logic [tfll_pkg::PROB_W-1:0]    i_base_err,
    input  wire logic [tfll_pkg::PROB_W-1:0]    i_map_err,
    input  wire logic                           i_last,
    output tfll_pkg::t_work                     o_work
);

    logic [tfll_pkg::PROB_W-1:0] r_tf;
    logic [tfll_pkg::GP_W-1:0]   r_gp;
    logic [tfll_pkg::CHAR_W-1:0] r_alt;

    logic                        variant;
    logic                        reference;
    logic [tfll_pkg::PROB_W-1:0] tf;
    logic [tfll_pkg::PROB_W-1:0] h;
    logic [tfll_pkg::PROB_W-1:0] frac_ref;
    logic [tfll_pkg::PROB_W-1:0] frac_var;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tf  <= '0;
            r_gp  <= tfll_pkg::GP_AA_AA;
            r_alt <= tfll_pkg::CH_UPPER_X;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tfll_pkg::CFG_TUMOR_FRACTION: r_tf  <= i_cfg_data;
                tfll_pkg::CFG_GENOTYPE_PAIR:  r_gp  <= i_cfg_data[tfll_pkg::GP_W-1:0];
                tfll_pkg::CFG_ALT_BASE:       r_alt <= i_cfg_data[tfll_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        variant   = tfll_pkg::lower_ascii(i_base_char) == tfll_pkg::lower_ascii(r_alt);
        reference = !variant && (i_base_char == tfll_pkg::CH_UPPER_R ||
                                 i_base_char == tfll_pkg::CH_LOWER_R);
        tf = tfll_pkg::clamp_one(r_tf);
        h  = tf >> 1;
        unique case (r_gp)
            tfll_pkg::GP_AA_AA: begin
                frac_ref = tfll_pkg::ONE;                  frac_var = '0;
            end
            tfll_pkg::GP_AA_AB: begin
                frac_ref = tfll_pkg::ONE - h;              frac_var = h;
            end
            tfll_pkg::GP_AA_BB: begin
                frac_ref = tfll_pkg::ONE - tf;             frac_var = tf;
            end
            tfll_pkg::GP_AB_AA: begin
                frac_ref = tfll_pkg::HALF + h;             frac_var = tfll_pkg::HALF - h;
            end
            tfll_pkg::GP_AB_AB: begin
                frac_ref = tfll_pkg::HALF;                 frac_var = tfll_pkg::HALF;
            end
            tfll_pkg::GP_AB_BB: begin
                frac_ref = tfll_pkg::HALF - h;             frac_var = tfll_pkg::HALF + h;
            end
            tfll_pkg::GP_BB_AA: begin
                frac_ref = tf;                             frac_var = tfll_pkg::ONE - tf;
            end
            tfll_pkg::GP_BB_AB: begin
                frac_ref = h;                              frac_var = tfll_pkg::ONE - h;
            end
            tfll_pkg::GP_BB_BB: begin
                frac_ref = '0;                             frac_var = tfll_pkg::ONE;
            end
            default: begin
                frac_ref = '0;                             frac_var = '0;
            end
        endcase
        o_work.q       = tfll_pkg::clamp_one(i_base_err);
        o_work.m       = tfll_pkg::clamp_one(i_map_err);
        o_work.v       = variant ? frac_var : frac_ref;
        o_work.counted = variant || reference;
        o_work.last    = i_last;
    end

endmodule
`default_nettype wire

// ===== sv/tfll_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end
`default_nettype none
module tfll_queue (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire tfll_pkg::t_work i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output tfll_pkg::t_work o_data
);

    localparam int PTR_W = $clog2(tfll_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tfll_pkg::QUEUE_DEPTH + 1);

    tfll_pkg::t_work r_mem [tfll_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CNT_W'(tfll_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(tfll_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(tfll_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tfll_back.sv =====
// Back end: term arithmetic, iterative log, saturating accumulation, result register
`default_nettype none
module tfll_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire tfll_pkg::t_work                  i_work,
    output logic                                  o_take,
    input  wire logic                             i_pop,
    output logic                                  o_empty,
    output logic signed [tfll_pkg::SUM_WIDTH-1:0] o_log_likelihood,
    output logic [tfll_pkg::CNT_W-1:0]            o_used_count,
    output logic                                  o_floor_hit
);

    localparam int F    = tfll_pkg::FRAC_BITS;
    localparam int PW   = tfll_pkg::PROB_W;
    localparam int SW   = tfll_pkg::SUM_WIDTH;
    localparam int BW   = F + 3;
    localparam int PAW  = 2 * PW;
    localparam int PVBW = PW + BW;
    localparam int TSW  = PVBW + 1;
    localparam int TW   = F + 2;
    localparam int KW   = $clog2(TW);
    localparam int MW   = tfll_pkg::LOG_MANT_BITS + 1;
    localparam int LFB  = tfll_pkg::LOG_FRAC_BITS;
    localparam int IW   = $clog2(LFB);
    localparam int LW   = LFB + KW + 1;
    localparam int MAGW = LW - 1;
    localparam int PRW  = MAGW + tfll_pkg::LN2_W;
    localparam int RS   = LFB + tfll_pkg::LN2_W - F;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_NORM = 7'b0001000,
        S_LOG  = 7'b0010000,
        S_LN   = 7'b0100000,
        S_ACC  = 7'b1000000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    tfll_pkg::t_work       r_item;
    logic [PAW-1:0]        r_pa;
    logic [PAW-1:0]        r_pb;
    logic [PAW-1:0]        r_pva;
    logic [PVBW-1:0]       r_pvb;
    logic [MW-1:0]         r_y;
    logic [KW-1:0]         r_k;
    logic                  r_zero;
    logic [LFB-1:0]        r_frac;
    logic [IW-1:0]         r_iter;
    logic [PRW-1:0]        r_prod;
    logic                  r_neg;
    logic signed [SW-1:0]  r_sum;
    logic [tfll_pkg::CNT_W-1:0] r_cnt;
    logic                  r_flr;
    logic                  r_out_valid;
    logic signed [SW-1:0]  r_out_sum;
    logic [tfll_pkg::CNT_W-1:0] r_out_cnt;
    logic                  r_out_flr;

    logic [PW-1:0]         a;
    logic [BW-1:0]         b;
    logic [TSW-1:0]        tsum;
    logic [TW-1:0]         t;
    logic [KW-1:0]         k;
    logic [5:0]            sh;
    logic [2*MW-1:0]       sq;
    logic [MW:0]           y2;
    logic [LW-1:0]         l2;
    logic [MAGW-1:0]       mag;
    logic [PRW-1:0]        rsum;
    logic signed [SW-1:0]  term_mag;
    logic signed [SW-1:0]  term;
    logic [SW:0]           ext;
    logic signed [SW-1:0]  n_sum;
    logic [tfll_pkg::CNT_W-1:0] n_cnt;
    logic                  n_flr;
    logic                  out_free;

    always_comb begin
        a = PW'((r_pa + PAW'(tfll_pkg::HALF)) >> F);
        b = BW'(r_item.q) + BW'(r_item.m) + BW'((r_pb + PAW'(tfll_pkg::HALF)) >> F);
        tsum = TSW'(r_pva) + TSW'(r_pvb) + TSW'(tfll_pkg::HALF);
        t = TW'(tsum >> F);
        k = '0;
        for (int i = 1; i < TW; i++) begin
            if (t[i]) k = KW'(i);
        end
        sh = 6'(tfll_pkg::LOG_MANT_BITS) - 6'(k);
        sq = r_y * r_y;
        y2 = sq[2*MW-1:tfll_pkg::LOG_MANT_BITS];
        l2 = (LW'(r_k) << LFB) - (LW'(F) << LFB) + LW'(r_frac);
        mag = l2[LW-1] ? MAGW'(-l2) : MAGW'(l2);
        rsum = r_prod + (PRW'(1) << (RS - 1));
        term_mag = SW'(rsum[PRW-1:RS]);
        term = r_zero ? {1'b1, {(SW-1){1'b0}}} : (r_neg ? -term_mag : term_mag);
        ext = {r_sum[SW-1], r_sum} + {term[SW-1], term};
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_flr = r_flr;
        if (r_item.counted) begin
            if (ext[SW] != ext[SW-1]) begin
                n_sum = ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end else begin
                n_sum = ext[SW-1:0];
            end
            if (r_cnt != '1) n_cnt = r_cnt + 1'b1;
            n_flr = r_flr || r_zero;
        end
    end

    assign out_free = !r_out_valid || i_pop;
    assign o_take   = (r_state == S_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = i_work.counted ? S_MUL1 : S_ACC;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_NORM;
            S_NORM: n_state = (t == '0) ? S_ACC : S_LOG;
            S_LOG:  if (r_iter == IW'(LFB - 1)) n_state = S_LN;
            S_LN:   n_state = S_ACC;
            S_ACC:  if (!r_item.last || out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_flr       <= 1'b0;
            r_out_valid <= 1'b0;
            r_zero      <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_zero <= 1'b0;
            end
            if (r_state == S_NORM) begin
                r_zero <= t == '0;
                r_iter <= '0;
            end
            if (r_state == S_LOG) begin
                r_iter <= r_iter + 1'b1;
            end
            if (r_out_valid && i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ACC && n_state == S_IDLE) begin
                if (r_item.last) begin
                    r_out_valid <= 1'b1;
                    r_sum       <= '0;
                    r_cnt       <= '0;
                    r_flr       <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    r_flr <= n_flr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_work;
        end
        if (r_state == S_MUL1) begin
            r_pa <= (PW'(tfll_pkg::ONE) - r_item.q) * (PW'(tfll_pkg::ONE) - r_item.m);
            r_pb <= r_item.q * r_item.m;
        end
        if (r_state == S_MUL2) begin
            r_pva <= r_item.v * a;
            r_pvb <= PVBW'(tfll_pkg::ONE - r_item.v) * PVBW'(b);
        end
        if (r_state == S_NORM) begin
            r_k    <= k;
            r_y    <= MW'(t) << sh;
            r_frac <= '0;
        end
        if (r_state == S_LOG) begin
            if (y2[MW]) begin
                r_y    <= y2[MW:1];
                r_frac <= {r_frac[LFB-2:0], 1'b1};
            end else begin
                r_y    <= y2[MW-1:0];
                r_frac <= {r_frac[LFB-2:0], 1'b0};
            end
        end
        if (r_state == S_LN) begin
            r_neg  <= l2[LW-1];
            r_prod <= PRW'(mag) * PRW'(tfll_pkg::LN2_Q30);
        end
        if (r_state == S_ACC && n_state == S_IDLE && r_item.last) begin
            r_out_sum <= n_sum;
            r_out_cnt <= n_cnt;
            r_out_flr <= n_flr;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_log_likelihood = r_out_sum;
    assign o_used_count     = r_out_cnt;
    assign o_floor_hit      = r_out_flr;

`include "assert_macros.svh"

    `ASSERT_SAME(a_log_normalized, r_state == S_LOG, r_y[MW-1], "log mantissa not normalized")
    `ASSERT_SAME(a_iter_bound, r_state == S_LOG, r_iter < IW'(LFB), "log iteration overrun")
    `ASSERT_NEXT(a_take_leaves_idle, o_take, r_state != S_IDLE, "accepted work not started")

endmodule
`default_nettype wire

// ===== tb/sv/tumor_fraction_log_likelihood_tb.sv =====
// Testbench: column log likelihood words predicted and checked against the block
`default_nettype none
module tumor_fraction_log_likelihood_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PROB_W        = tfll_pkg::PROB_W;
    localparam int  CHAR_W        = tfll_pkg::CHAR_W;
    localparam int  GP_W          = tfll_pkg::GP_W;
    localparam int  CFG_IDX_W     = tfll_pkg::CFG_IDX_W;
    localparam int  SUM_WIDTH     = tfll_pkg::SUM_WIDTH;
    localparam int  CNT_W         = tfll_pkg::CNT_W;
    localparam int  FRAC_BITS     = tfll_pkg::FRAC_BITS;
    localparam int  LOG_MANT_BITS = tfll_pkg::LOG_MANT_BITS;
    localparam int  LOG_FRAC_BITS = tfll_pkg::LOG_FRAC_BITS;
    localparam int  SETTLE_CYCLES = 160;
    localparam int  CYCLE_LIMIT   = 1000000;
    localparam logic [PROB_W-1:0] PROB_MAX = '1;

    typedef struct {
        logic signed [SUM_WIDTH-1:0] sum;
        logic [CNT_W-1:0]            count;
        logic                        floor_hit;
    } t_column;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [PROB_W-1:0]     i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [CHAR_W-1:0]     i_base_char = '0;
    logic [PROB_W-1:0]     i_base_err = '0;
    logic [PROB_W-1:0]     i_map_err = '0;
    logic                  i_last = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic signed [SUM_WIDTH-1:0] o_log_likelihood;
    logic [CNT_W-1:0]      o_used_count;
    logic                  o_floor_hit;

    tumor_fraction_log_likelihood dut (.*);

    always #2 i_clk = ~i_clk;

    logic [PROB_W-1:0] tf_reg = '0;
    logic [GP_W-1:0]   gp_reg = tfll_pkg::GP_AA_AA;
    logic [CHAR_W-1:0] alt_reg = tfll_pkg::CH_UPPER_X;
    longint            sum_run = 0;
    int unsigned       count_run = 0;
    bit                floor_run = 0;
    t_column           columns_due[$];
    int                errors = 0;
    int                send_idle = 0;
    int                recv_stall = 0;
    int                cycles = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint unsigned clip(input logic [PROB_W-1:0] x);
        return (x > tfll_pkg::ONE) ? longint'(tfll_pkg::ONE) : longint'(x);
    endfunction

    function automatic longint unsigned allele_fraction(input bit variant);
        longint unsigned one, half, tf, h, r, x;
        one = tfll_pkg::ONE; half = tfll_pkg::HALF; tf = clip(tf_reg); h = tf >> 1;
        case (gp_reg)
            tfll_pkg::GP_AA_AA: begin r = one;      x = 0;        end
            tfll_pkg::GP_AA_AB: begin r = one - h;  x = h;        end
            tfll_pkg::GP_AA_BB: begin r = one - tf; x = tf;       end
            tfll_pkg::GP_AB_AA: begin r = half + h; x = half - h; end
            tfll_pkg::GP_AB_AB: begin r = half;     x = half;     end
            tfll_pkg::GP_AB_BB: begin r = half - h; x = half + h; end
            tfll_pkg::GP_BB_AA: begin r = tf;       x = one - tf; end
            tfll_pkg::GP_BB_AB: begin r = h;        x = one - h;  end
            tfll_pkg::GP_BB_BB: begin r = 0;        x = one;      end
            default:            begin r = 0;        x = 0;        end
        endcase
        return variant ? x : r;
    endfunction

    function automatic longint natural_log(input longint unsigned t);
        int k;
        longint unsigned y, frac, mag, prod, r;
        longint l2;
        k = 0;
        frac = 0;
        while (k < 62 && (t >> (k + 1)) != 0) k++;
        y = (k <= LOG_MANT_BITS) ? (t << (LOG_MANT_BITS - k)) : (t >> (k - LOG_MANT_BITS));
        for (int i = 0; i < LOG_FRAC_BITS; i++) begin
            y = (y * y) >> LOG_MANT_BITS;
            if (y >= (64'd2 << LOG_MANT_BITS)) begin
                y >>= 1;
                frac |= 64'd1 << (LOG_FRAC_BITS - 1 - i);
            end
        end
        l2 = longint'(k - FRAC_BITS) * (longint'(1) << LOG_FRAC_BITS) + longint'(frac);
        mag = (l2 < 0) ? longint'(-l2) : l2;
        prod = mag * longint'(tfll_pkg::LN2_Q30);
        r = (prod + (64'd1 << (LOG_FRAC_BITS + 30 - FRAC_BITS - 1)))
            >> (LOG_FRAC_BITS + 30 - FRAC_BITS);
        return (l2 < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint saturate_sum(input longint a, input longint b);
        longint hi, lo;
        hi = (longint'(1) << (SUM_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (b > 0 && a > hi - b) return hi;
        if (b < 0 && a < lo - b) return lo;
        return a + b;
    endfunction

    function automatic void accumulate_base(input logic [CHAR_W-1:0] c,
            input logic [PROB_W-1:0] qe, input logic [PROB_W-1:0] me, input logic lst);
        bit variant, refb;
        longint unsigned one, half, q, m, v, a, b, t;
        t_column col;
        variant = tfll_pkg::lower_ascii(c) == tfll_pkg::lower_ascii(alt_reg);
        refb = !variant && (c == tfll_pkg::CH_UPPER_R || c == tfll_pkg::CH_LOWER_R);
        if (variant || refb) begin
            one = tfll_pkg::ONE; half = tfll_pkg::HALF;
            q = clip(qe); m = clip(me);
            v = allele_fraction(variant);
            a = ((one - q) * (one - m) + half) >> FRAC_BITS;
            b = q + m + ((q * m + half) >> FRAC_BITS);
            t = (v * a + (one - v) * b + half) >> FRAC_BITS;
            if (t == 0) begin
                sum_run = saturate_sum(sum_run, -(longint'(1) << (SUM_WIDTH - 1)));
                floor_run = 1;
            end else begin
                sum_run = saturate_sum(sum_run, natural_log(t));
            end
            if (count_run < 65535) count_run++;
        end
        if (lst) begin
            col.sum = sum_run[SUM_WIDTH-1:0];
            col.count = count_run[CNT_W-1:0];
            col.floor_hit = floor_run;
            columns_due.insert(columns_due.size(), col);
            sum_run = 0; count_run = 0; floor_run = 0;
        end
    endfunction

    task automatic send_base(input logic [CHAR_W-1:0] c, input logic [PROB_W-1:0] q,
            input logic [PROB_W-1:0] m, input logic lst);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_base_char <= c;
        i_base_err <= q;
        i_map_err <= m;
        i_last <= lst;
        do @(posedge i_clk); while (full);
        accumulate_base(c, q, m, lst);
    endtask

    task automatic drain;
        push <= 1'b0;
        while (columns_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            tfll_pkg::CFG_TUMOR_FRACTION: tf_reg = val;
            tfll_pkg::CFG_GENOTYPE_PAIR:  gp_reg = val[GP_W-1:0];
            tfll_pkg::CFG_ALT_BASE:       alt_reg = val[CHAR_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CHAR_W-1:0] pick_char;
        case ($urandom_range(9))
            0: return tfll_pkg::CH_UPPER_R;
            1: return tfll_pkg::CH_LOWER_R;
            2, 3: return alt_reg;
            4: return tfll_pkg::lower_ascii(alt_reg);
            5: return (alt_reg >= 8'd97 && alt_reg <= 8'd122) ?
                      alt_reg - tfll_pkg::CASE_GAP : alt_reg;
            default: return CHAR_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [PROB_W-1:0] pick_prob;
        case ($urandom_range(9))
            0: return '0;
            1: return tfll_pkg::ONE;
            2: return PROB_W'($urandom_range(int'(PROB_MAX)));
            3: return PROB_W'($urandom_range(int'(tfll_pkg::ONE)));
            default: return PROB_W'($urandom_range(3000));
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_column want;
        if (i_rst_n && pop && !empty) begin
            if (columns_due.size() == 0) begin
                report("unexpected word", o_log_likelihood, 0);
            end else begin
                want = columns_due.pop_front();
                if (o_log_likelihood !== want.sum)
                    report("log_likelihood", o_log_likelihood, want.sum);
                if (o_used_count !== want.count)
                    report("used_count", o_used_count, want.count);
                if (o_floor_hit !== want.floor_hit)
                    report("floor_hit", o_floor_hit, want.floor_hit);
            end
        end
        pop <= ($urandom_range(99) >= recv_stall);
    end

    task automatic test_directed;
        send_base(tfll_pkg::CH_UPPER_X, '0, '0, 1'b0);
        send_base(8'd120, tfll_pkg::ONE, '0, 1'b0);
        send_base(tfll_pkg::CH_UPPER_R, '0, tfll_pkg::ONE, 1'b0);
        send_base(tfll_pkg::CH_LOWER_R, PROB_MAX, PROB_MAX, 1'b0);
        send_base(8'd65, 17'd100, 17'd100, 1'b1);
        send_base(8'd0, '0, '0, 1'b1);
        send_base(8'd255, tfll_pkg::ONE, tfll_pkg::ONE, 1'b1);
        send_base(tfll_pkg::CH_UPPER_R, tfll_pkg::ONE, '0, 1'b0);
        send_base(tfll_pkg::CH_UPPER_R, tfll_pkg::ONE, '0, 1'b1);
        drain();
        write_reg(tfll_pkg::CFG_ALT_BASE, PROB_W'(tfll_pkg::CH_UPPER_R));
        send_base(tfll_pkg::CH_UPPER_R, 17'd500, 17'd20, 1'b0);
        send_base(tfll_pkg::CH_LOWER_R, 17'd500, 17'd20, 1'b1);
        drain();
        write_reg(tfll_pkg::CFG_ALT_BASE, PROB_W'(tfll_pkg::CH_LOWER_R));
        send_base(tfll_pkg::CH_UPPER_R, 17'd7, 17'd9, 1'b1);
        drain();
        write_reg(tfll_pkg::CFG_ALT_BASE, PROB_W'(tfll_pkg::CH_UPPER_X));
    endtask

    task automatic test_genotypes;
        logic [PROB_W-1:0] fracs[4];
        fracs = '{'0, tfll_pkg::ONE, PROB_MAX, 17'd20000};
        foreach (fracs[f]) begin
            write_reg(tfll_pkg::CFG_TUMOR_FRACTION, fracs[f]);
            for (int g = 0; g < 16; g++) begin
                write_reg(tfll_pkg::CFG_GENOTYPE_PAIR, PROB_W'(g));
                send_base(tfll_pkg::CH_UPPER_R, 17'd300, 17'd40, 1'b0);
                send_base(tfll_pkg::CH_UPPER_X, 17'd300, 17'd40, 1'b0);
                send_base(tfll_pkg::CH_LOWER_R, '0, '0, 1'b1);
                drain();
            end
        end
    endtask

    task automatic test_random(input int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            write_reg(tfll_pkg::CFG_TUMOR_FRACTION, pick_prob());
            write_reg(tfll_pkg::CFG_GENOTYPE_PAIR, PROB_W'($urandom_range(15)));
            write_reg(tfll_pkg::CFG_ALT_BASE, ($urandom_range(3) == 0) ?
                      PROB_W'($urandom_range(255)) : PROB_W'(tfll_pkg::CH_UPPER_X));
            for (int col = 0; col < 12; col++) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                for (int j = 0; j < len; j++)
                    send_base(pick_char(), pick_prob(), pick_prob(), j == len - 1);
                sent += len;
            end
            drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_genotypes();
        send_idle = 0;  recv_stall = 0;  test_random(400);
        send_idle = 59; recv_stall = 0;  test_random(350);
        send_idle = 0;  recv_stall = 59; test_random(350);
        send_idle = 11; recv_stall = 11; test_random(350);
        drain();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== tumor_fraction_log_likelihood.f =====
+incdir+sv
sv/tfll_pkg.sv
sv/tfll_front.sv
sv/tfll_queue.sv
sv/tfll_back.sv
sv/tumor_fraction_log_likelihood.sv
tb/sv/tumor_fraction_log_likelihood_tb.sv
